/* rtl/rpr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the three-phase RMS power regulator.
// No dependencies.
package rpr_pkg;

  localparam int unsigned SUM_W    = 40;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned ROOT_W   = SUM_W / 2;
  localparam int unsigned PROD_W   = ROOT_W + SCALE_W;
  localparam int unsigned TOTAL_W  = 18;
  localparam int unsigned ANGLE_W  = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned CNT_W    = 6;

  localparam logic [15:0] MIN_POWER  = 16'd150;
  localparam logic signed [15:0] CORR_ANGLE = 16'sd7000;
  localparam logic signed [15:0] OFF_DELTA  = 16'sd500;

  localparam logic [15:0] RST_POWER_MAX = 16'd3000;
  localparam logic [23:0] RST_SCALE     = 24'd65536;
  localparam logic [15:0] RST_LOOP_LAG  = 16'd10;
  localparam logic [15:0] RST_WINDOW    = 16'd1024;
  localparam logic [14:0] RST_FLOOR     = 15'd100;
  localparam logic [14:0] RST_CEILING   = 15'd9000;
  localparam logic signed [15:0] RST_ANGLE =
    $signed({1'b0, RST_FLOOR}) - OFF_DELTA;

  // Iteration counts of the serial divider
  localparam logic [CNT_W-1:0] DIV_STEPS_SUM = CNT_W'(SUM_W);
  localparam logic [CNT_W-1:0] DIV_STEPS_ERR = CNT_W'(TOTAL_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_REQUEST = 3'd0,
    REG_POWER_MAX     = 3'd1,
    REG_CURRENT_SCALE = 3'd2,
    REG_VOLTAGE_SCALE = 3'd3,
    REG_LOOP_LAG      = 3'd4,
    REG_SAMPLE_WINDOW = 3'd5,
    REG_ANGLE_FLOOR   = 3'd6,
    REG_ANGLE_CEILING = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_POW,
    ST_TOT,
    ST_ANG,
    ST_DONE
  } state_e;

  function automatic logic [15:0] sat16(input logic [TOTAL_W-1:0] v);
    return (v > TOTAL_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

/* rtl/rpr_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on rpr_pkg.
interface rpr_in_if;
  import rpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sum_squares;
  logic             zc_phase_a;
  logic             zc_phase_b;
  logic             zc_phase_c;
  modport source (output valid, sum_squares, zc_phase_a, zc_phase_b, zc_phase_c,
                  input ready);
  modport sink (input valid, sum_squares, zc_phase_a, zc_phase_b, zc_phase_c,
                output ready);
endinterface

interface rpr_out_if;
  import rpr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                phase_index;
  logic                      was_voltage;
  logic [15:0]               rms_level;
  logic [15:0]               phase_power;
  logic [TOTAL_W-1:0]        total_power;
  logic [15:0]               average_power;
  logic [15:0]               mean_power;
  logic signed [15:0]        fire_angle_a;
  logic signed [15:0]        fire_angle_b;
  logic signed [15:0]        fire_angle_c;
  logic signed [15:0]        regulator_angle;
  modport source (output valid, phase_index, was_voltage, rms_level, phase_power,
                  total_power, average_power, mean_power, fire_angle_a,
                  fire_angle_b, fire_angle_c, regulator_angle, input ready);
  modport sink (input valid, phase_index, was_voltage, rms_level, phase_power,
                total_power, average_power, mean_power, fire_angle_a,
                fire_angle_b, fire_angle_c, regulator_angle, output ready);
endinterface

interface rpr_cfg_if;
  import rpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rpr_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rpr_pkg.
module rpr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rpr_pkg::SUM_W-1:0]   dividend_i,
  input  logic [rpr_pkg::WIN_W-1:0]   divisor_i,
  input  logic [rpr_pkg::CNT_W-1:0]   steps_i,
  output logic                        done_o,
  output logic [rpr_pkg::SUM_W-1:0]   quotient_o
);
  import rpr_pkg::*;

  logic [WIN_W-1:0] rem_q, rem_d, dsr_q;
  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [WIN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_d   = ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= steps_i;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

/* rtl/rpr_isqrt.sv */
`timescale 1ns / 1ps
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on rpr_pkg.
module rpr_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rpr_pkg::SUM_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [rpr_pkg::ROOT_W-1:0] root_o
);
  import rpr_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 1;

  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [4:0]        cnt_q;
  logic              done_q;
  logic [REM_W+1:0]  rem_sh, trial, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, rad_q[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == 5'd1);
      if (start_i) begin
        cnt_q <= 5'(ROOT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

/* rtl/rpr_mul.sv */
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: root times Q8.16 scale, one bit per cycle.
// Depends on rpr_pkg.
module rpr_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rpr_pkg::ROOT_W-1:0]  mcand_i,
  input  logic [rpr_pkg::SCALE_W-1:0] scale_i,
  output logic                        done_o,
  output logic [rpr_pkg::PROD_W-1:0]  product_o
);
  import rpr_pkg::*;

  logic [PROD_W-1:0]  p_q;
  logic [SCALE_W-1:0] b_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic [SCALE_W:0]   sum;

  assign sum = {1'b0, p_q[PROD_W-1:ROOT_W]} + (p_q[0] ? {1'b0, b_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == 5'd1);
      if (start_i) begin
        cnt_q <= 5'(ROOT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{SCALE_W{1'b0}}, mcand_i};
      b_q <= scale_i;
    end else if (cnt_q != '0) begin
      p_q <= {sum, p_q[ROOT_W-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = p_q;
endmodule

/* rtl/three_phase_rms_power_regulator.sv */
`timescale 1ns / 1ps
// Three-phase RMS power regulator top level.
// Depends on rpr_pkg, rpr_if, rpr_div, rpr_isqrt, rpr_mul.
//
// Usage:
//  in_i  : one transaction per finished sum of squares, alternating current
//          then voltage for phases 0, 1, 2, with the three zero-cross flags.
//  out_o : one result transaction per input: RMS level, phase/total/average/
//          mean power and the three triac angles plus the regulator angle.
//  cfg_i : register writes (index 0..7), always ready; write only while idle.
// Flow: one item at a time. A current item passes a serial divide by the
//  window, a serial square root, a serial scale multiply and the load of
//  the output register. A voltage item adds power, totals and, unless the
//  setpoint is zero, a serial divide by the loop lag. The next input can
//  be taken in the cycle after the result loads. The serial divider is
//  shared by both divisions.
// The result sits in an output register, so the next input is taken while a
//  result waits. If the receiver stalls, the following item finishes its work
//  and then holds in the final state until the output register frees up.
// Reset: registers return to their defaults, current is expected first on
//  phase 0, all powers clear and the angles sit at the off angle (floor-500).
module three_phase_rms_power_regulator (
  input  logic clk_i,
  input  logic rst_ni,
  rpr_in_if.sink    in_i,
  rpr_out_if.source out_o,
  rpr_cfg_if.sink   cfg_i
);
  import rpr_pkg::*;

  // configuration registers
  logic [15:0]        power_request_q, power_max_q, loop_lag_q, sample_window_q;
  logic [SCALE_W-1:0] current_scale_q, voltage_scale_q;
  logic [ANGLE_W-1:0] angle_floor_q, angle_ceiling_q;

  state_e state_q, state_d;

  // item context
  logic [2:0]       zc_q;
  logic [1:0]       ph_q;
  logic             isv_q;

  // regulator state
  logic [1:0]         phase_cnt_q;
  logic               expv_q;
  logic [15:0]        cur_q, rms_q, avg_q, mean_v_q;
  logic [15:0]        ppp_q [3];
  logic [TOTAL_W-1:0] hist_q [3];
  logic signed [15:0] acc_q;
  logic               neg_q;
  logic               out_valid_q;

  // unit handshakes
  logic               div_start, sq_start, mul_start;
  logic               div_done, sq_done, mul_done;
  logic [SUM_W-1:0]   div_dividend, div_quo;
  logic [WIN_W-1:0]   div_divisor;
  logic [CNT_W-1:0]   div_steps;
  logic [ROOT_W-1:0]  root;
  logic [PROD_W-1:0]  product;

  logic               in_acc, out_load;
  logic [15:0]        win, lag, pset, rms_c;
  logic [TOTAL_W-1:0] total_c;
  logic signed [TOTAL_W:0] err;
  logic [TOTAL_W-1:0] mag;
  logic [19:0]        hsum;
  logic [TOTAL_W:0]   avg_sum;
  logic signed [15:0] off_angle;
  logic signed [19:0] step, acc_next, flo20, ceil20;
  logic               corr;
  logic [15:0]        mean_c;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_request_q <= '0;
      power_max_q     <= RST_POWER_MAX;
      current_scale_q <= RST_SCALE;
      voltage_scale_q <= RST_SCALE;
      loop_lag_q      <= RST_LOOP_LAG;
      sample_window_q <= RST_WINDOW;
      angle_floor_q   <= RST_FLOOR;
      angle_ceiling_q <= RST_CEILING;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_POWER_REQUEST: power_request_q <= cfg_i.data[15:0];
        REG_POWER_MAX:     power_max_q     <= cfg_i.data[15:0];
        REG_CURRENT_SCALE: current_scale_q <= cfg_i.data;
        REG_VOLTAGE_SCALE: voltage_scale_q <= cfg_i.data;
        REG_LOOP_LAG:      loop_lag_q      <= cfg_i.data[15:0];
        REG_SAMPLE_WINDOW: sample_window_q <= cfg_i.data[15:0];
        REG_ANGLE_FLOOR:   angle_floor_q   <= cfg_i.data[ANGLE_W-1:0];
        REG_ANGLE_CEILING: angle_ceiling_q <= cfg_i.data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero divisors behave as one
  assign win = (sample_window_q == '0) ? 16'd1 : sample_window_q;
  assign lag = (loop_lag_q == '0) ? 16'd1 : loop_lag_q;

  // clamped setpoint: max clamp wins over the minimum cutoff
  always_comb begin
    if (power_request_q > power_max_q) begin
      pset = power_max_q;
    end else if (power_request_q < MIN_POWER) begin
      pset = '0;
    end else begin
      pset = power_request_q;
    end
  end

  assign total_c = TOTAL_W'(ppp_q[0]) + TOTAL_W'(ppp_q[1]) + TOTAL_W'(ppp_q[2]);
  assign err     = $signed({3'b000, pset}) - $signed({1'b0, total_c});
  assign mag     = err[TOTAL_W] ? TOTAL_W'(-err) : err[TOTAL_W-1:0];
  assign off_angle = $signed({1'b0, angle_floor_q}) - OFF_DELTA;

  // RMS = sat16((root * scale) >> 8)
  assign rms_c = (product[PROD_W-1:24] != '0) ? 16'hFFFF : product[23:8];

  // Shared divider: sum/window at acceptance, |error|/lag after totals
  always_comb begin
    if (state_q == ST_IDLE) begin
      div_dividend = in_i.sum_squares;
      div_divisor  = win;
      div_steps    = DIV_STEPS_SUM;
    end else begin
      div_dividend = {mag, {(SUM_W-TOTAL_W){1'b0}}};
      div_divisor  = lag;
      div_steps    = DIV_STEPS_ERR;
    end
  end

  rpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rpr_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (div_quo),
    .done_o     (sq_done),
    .root_o     (root)
  );

  rpr_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (root),
    .scale_i   (isv_q ? voltage_scale_q : current_scale_q),
    .done_o    (mul_done),
    .product_o (product)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    sq_start  = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = isv_q ? ST_POW : ST_DONE;
        end
      end
      ST_POW: state_d = ST_TOT;
      ST_TOT: begin
        if (pset != '0) begin
          div_start = 1'b1;
          state_d   = ST_ANG;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ANG: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // angle integration: truncate toward zero, then clamp floor first
  assign step   = neg_q ? -$signed({2'b00, div_quo[TOTAL_W-1:0]})
                        :  $signed({2'b00, div_quo[TOTAL_W-1:0]});
  assign flo20  = $signed({5'b0, angle_floor_q});
  assign ceil20 = $signed({5'b0, angle_ceiling_q});
  assign acc_next = 20'(acc_q) + step;

  // history mean (sums grow to 20 bits) and running average (19-bit sum)
  assign hsum    = 20'(hist_q[0]) + 20'(hist_q[1]) + 20'(hist_q[2]);
  assign avg_sum = (TOTAL_W+1)'(avg_q) + (TOTAL_W+1)'(total_c);
  assign mean_c  = sat16(TOTAL_W'((hsum + 20'(hist_q[0])) >> 2));

  // correction band: Pmax/6.9 < setpoint < Pmax/4.5
  assign corr = (23'(pset) * 23'd69 > 23'(power_max_q) * 23'd10) &&
                (23'(pset) * 23'd9 < 23'(power_max_q) * 23'd2);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_cnt_q <= '0;
      expv_q      <= 1'b0;
      cur_q       <= '0;
      avg_q       <= '0;
      acc_q       <= RST_ANGLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ppp_q[i]  <= '0;
        hist_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_MUL && mul_done && !isv_q) begin
        cur_q  <= rms_c;
        expv_q <= 1'b1;
      end
      if (state_q == ST_POW) begin
        expv_q      <= 1'b0;
        ppp_q[ph_q] <= 16'((32'(cur_q) * 32'(rms_q)) >> 16);
      end
      if (state_q == ST_TOT) begin
        phase_cnt_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          avg_q     <= sat16(avg_sum[TOTAL_W:1]);
          hist_q[2] <= hist_q[1];
          hist_q[1] <= hist_q[0];
          hist_q[0] <= total_c;
        end
        if (pset == '0) begin
          acc_q <= off_angle;
        end
      end
      if (state_q == ST_ANG && div_done) begin
        if (acc_next < flo20) begin
          acc_q <= $signed({1'b0, angle_floor_q});
        end else if (acc_next > ceil20) begin
          acc_q <= $signed({1'b0, angle_ceiling_q});
        end else begin
          acc_q <= acc_next[15:0];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      zc_q  <= {in_i.zc_phase_c, in_i.zc_phase_b, in_i.zc_phase_a};
      ph_q  <= (phase_cnt_q == 2'd3) ? 2'd0 : phase_cnt_q;
      isv_q <= expv_q;
    end
    if (state_q == ST_MUL && mul_done) begin
      rms_q <= rms_c;
    end
    if (state_q == ST_TOT) begin
      neg_q    <= err[TOTAL_W];
      mean_v_q <= sat16(TOTAL_W'((hsum + 20'(total_c)) >> 2));
    end
    if (out_load) begin
      out_o.phase_index     <= ph_q;
      out_o.was_voltage     <= isv_q;
      out_o.rms_level       <= rms_q;
      out_o.phase_power     <= ppp_q[ph_q];
      out_o.total_power     <= total_c;
      out_o.average_power   <= avg_q;
      out_o.mean_power      <= (isv_q && ph_q == 2'd2) ? mean_v_q : mean_c;
      out_o.fire_angle_a    <= zc_q[0] ? acc_q : off_angle;
      out_o.fire_angle_b    <= zc_q[1] ? acc_q : off_angle;
      out_o.fire_angle_c    <= (corr && (&zc_q)) ? CORR_ANGLE
                               : (zc_q[2] ? acc_q : off_angle);
      out_o.regulator_angle <= acc_q;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready) else $error("input taken while busy");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_cnt_q != 2'd3) else $error("phase counter out of range");
  a_mul_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL) else $error("stray multiplier done");
  a_sqrt_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_SQRT) else $error("stray root done");
`endif
endmodule

/* verif/tb_three_phase_rms_power_regulator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the three-phase RMS power regulator.
// Depends on rpr_pkg, rpr_if and the regulator RTL.
module tb_three_phase_rms_power_regulator;
  import rpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES = 600;

  // One expected/observed result transaction
  typedef struct packed {
    logic [1:0]         phase;
    logic               is_volt;
    logic [15:0]        rms;
    logic [15:0]        pwr;
    logic [TOTAL_W-1:0] tot;
    logic [15:0]        avg;
    logic [15:0]        mean;
    logic [15:0]        fa;
    logic [15:0]        fb;
    logic [15:0]        fc;
    logic [15:0]        reg_ang;
  } reading_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [2:0]       zc;
  } sample_t;

  logic clk;
  logic rst_n;

  rpr_in_if  in_if ();
  rpr_out_if out_if ();
  rpr_cfg_if cfg_if ();

  three_phase_rms_power_regulator i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Pending samples (driver side) and expected readings (checker side)
  sample_t  sample_q[$];
  reading_t reading_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors;
  int unsigned checked;
  int unsigned accepted;
  int unsigned volt_count;
  int unsigned corr_hits;
  int unsigned hold_cnt;
  bit          hold_done;
  longint unsigned cycles;

  // Shadow copy of the register file
  longint unsigned m_request, m_pmax, m_cscale, m_vscale;
  longint unsigned m_lag, m_window, m_floor, m_ceiling;

  // Shadow copy of the regulator state
  int unsigned     m_phase;
  bit              m_expect_volt;
  longint unsigned m_cur_latch;
  longint unsigned m_pwr[3];
  longint unsigned m_avg;
  longint unsigned m_hist[3];
  int              m_angle;

  function automatic longint unsigned sat_16(longint unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned power_setpoint();
    if (m_request > m_pmax) return m_pmax;
    if (m_request < longint'(MIN_POWER)) return 0;
    return m_request;
  endfunction

  function automatic void reset_model();
    m_request = 0;
    m_pmax = RST_POWER_MAX;
    m_cscale = RST_SCALE;
    m_vscale = RST_SCALE;
    m_lag = RST_LOOP_LAG;
    m_window = RST_WINDOW;
    m_floor = RST_FLOOR;
    m_ceiling = RST_CEILING;
    m_phase = 0;
    m_expect_volt = 0;
    m_cur_latch = 0;
    m_avg = 0;
    m_angle = int'(m_floor) - 500;
    for (int i = 0; i < 3; i++) begin
      m_pwr[i] = 0;
      m_hist[i] = 0;
    end
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_POWER_REQUEST: m_request = d[15:0];
      REG_POWER_MAX:     m_pmax = d[15:0];
      REG_CURRENT_SCALE: m_cscale = d;
      REG_VOLTAGE_SCALE: m_vscale = d;
      REG_LOOP_LAG:      m_lag = d[15:0];
      REG_SAMPLE_WINDOW: m_window = d[15:0];
      REG_ANGLE_FLOOR:   m_floor = d[14:0];
      REG_ANGLE_CEILING: m_ceiling = d[14:0];
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one measurement and returns the reading
  function automatic reading_t predict_reading(sample_t s);
    reading_t        r;
    int unsigned     ph;
    longint unsigned win, lag, rms, pset, tot, mean;
    longint          a;
    bit              is_v, have_mean, corr;
    int              off;
    int              fire[3];
    ph = m_phase;
    win = (m_window != 0) ? m_window : 1;
    is_v = m_expect_volt;
    have_mean = 0;
    mean = 0;
    rms = sat_16((int_sqrt(s.sum / win) * (is_v ? m_vscale : m_cscale)) >> 8);
    pset = power_setpoint();
    if (!is_v) begin
      m_cur_latch = rms;
      m_expect_volt = 1;
    end else begin
      lag = (m_lag != 0) ? m_lag : 1;
      m_expect_volt = 0;
      volt_count++;
      m_pwr[ph] = sat_16((m_cur_latch * rms) >> 16);
      tot = m_pwr[0] + m_pwr[1] + m_pwr[2];
      if (ph == 2) begin
        mean = sat_16((m_hist[0] + m_hist[1] + m_hist[2] + tot) / 4);
        have_mean = 1;
        m_avg = sat_16((m_avg + tot) / 2);
        m_hist[2] = m_hist[1];
        m_hist[1] = m_hist[0];
        m_hist[0] = tot;
      end
      if (pset > 0) begin
        a = longint'(m_angle) + (longint'(pset) - longint'(tot)) / longint'(lag);
        if (a < longint'(m_floor)) a = m_floor;
        else if (a > longint'(m_ceiling)) a = m_ceiling;
        m_angle = int'(a);
      end else begin
        m_angle = int'(m_floor) - 500;
      end
      m_phase = (ph + 1 >= 3) ? 0 : ph + 1;
    end
    tot = m_pwr[0] + m_pwr[1] + m_pwr[2];
    off = int'(m_floor) - 500;
    for (int i = 0; i < 3; i++) fire[i] = s.zc[i] ? m_angle : off;
    corr = (pset * 69 > m_pmax * 10) && (pset * 9 < m_pmax * 2);
    if (corr && (&s.zc)) begin
      fire[2] = CORR_ANGLE;
      corr_hits++;
    end
    if (!have_mean) mean = sat_16((m_hist[0] + m_hist[1] + m_hist[2] + m_hist[0]) / 4);
    r.phase = ph[1:0];
    r.is_volt = is_v;
    r.rms = rms[15:0];
    r.pwr = m_pwr[ph][15:0];
    r.tot = tot[TOTAL_W-1:0];
    r.avg = m_avg[15:0];
    r.mean = mean[15:0];
    r.fa = fire[0][15:0];
    r.fb = fire[1][15:0];
    r.fc = fire[2][15:0];
    r.reg_ang = m_angle[15:0];
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, reading_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Input driver: on each accepted transaction the expected reading is
  // queued, then the next sample is offered unless the sender idles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        reading_q.push_back(predict_reading(
          '{sum: in_if.sum_squares,
            zc: {in_if.zc_phase_c, in_if.zc_phase_b, in_if.zc_phase_a}}));
        accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = sample_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.sum_squares <= s.sum;
          in_if.zc_phase_a <= s.zc[0];
          in_if.zc_phase_b <= s.zc[1];
          in_if.zc_phase_c <= s.zc[2];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once the run is well under way
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted >= 400) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        reading_t got;
        reading_t exp_r;
        got = '{out_if.phase_index, out_if.was_voltage, out_if.rms_level,
                out_if.phase_power, out_if.total_power, out_if.average_power,
                out_if.mean_power, out_if.fire_angle_a, out_if.fire_angle_b,
                out_if.fire_angle_c, out_if.regulator_angle};
        checked++;
        if (reading_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          exp_r = reading_q.pop_front();
          if (got.phase !== exp_r.phase || got.is_volt !== exp_r.is_volt ||
              got.rms !== exp_r.rms || got.pwr !== exp_r.pwr ||
              got.tot !== exp_r.tot || got.avg !== exp_r.avg ||
              got.mean !== exp_r.mean || got.fa !== exp_r.fa ||
              got.fb !== exp_r.fb || got.fc !== exp_r.fc ||
              got.reg_ang !== exp_r.reg_ang) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result %0d", checked);
              $display("  expected %p", exp_r);
              $display("  actual   %p", got);
            end
          end
        end
      end
      out_if.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] d);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, d);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued sample has been taken and answered, then let
  // the block settle before registers change.
  task automatic drain();
    wait (sample_q.size() == 0 && !in_if.valid && reading_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sum of squares: mostly a plausible RMS squared times the window,
  // otherwise raw 40-bit noise or the extremes.
  function automatic logic [SUM_W-1:0] pick_sum();
    int unsigned     sel;
    longint unsigned root, v;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return '1;
    if (sel < 30) return SUM_W'({$urandom(), $urandom()});
    root = (sel < 80) ? $urandom_range(400) : $urandom_range(4000);
    v = root * root * ((m_window != 0) ? m_window : 1) + $urandom_range(1000);
    return v[SUM_W-1:0];
  endfunction

  function automatic logic [2:0] pick_zc();
    return ($urandom_range(99) < 70) ? 3'b111 : 3'($urandom());
  endfunction

  task automatic push_sample(logic [SUM_W-1:0] sum, logic [2:0] zc);
    sample_q.push_back('{sum: sum, zc: zc});
  endtask

  // New register set for one random phase; extremes turn up now and then
  task automatic random_config();
    logic [CFG_DAT_W-1:0] pmax, req, fl, cl;
    pmax = ($urandom_range(9) == 0) ? 24'($urandom_range(1) * 16'hFFFF)
                                    : 24'($urandom_range(6000, 200));
    case ($urandom_range(6))
      0: req = '0;
      1: req = 24'(MIN_POWER - 16'd1);
      2: req = 24'(MIN_POWER);
      3: req = pmax / 5;                 // a fifth of the max, in the correction band when not cut off
      4: req = 24'($urandom());          // any 16 bits, upper bits ignored
      default: req = 24'($urandom_range(pmax + 200));
    endcase
    fl = ($urandom_range(9) == 0) ? 24'h7FFF : 24'($urandom_range(2000));
    cl = ($urandom_range(9) == 0) ? 24'($urandom_range(500)) : 24'($urandom_range(32767, 3000));
    write_reg(REG_POWER_MAX, pmax);
    write_reg(REG_POWER_REQUEST, req);
    write_reg(REG_CURRENT_SCALE, ($urandom_range(7) == 0) ? 24'($urandom())
                                 : 24'($urandom_range(131072, 8192)));
    write_reg(REG_VOLTAGE_SCALE, ($urandom_range(7) == 0) ? 24'($urandom())
                                 : 24'($urandom_range(262144, 16384)));
    write_reg(REG_LOOP_LAG, ($urandom_range(7) == 0) ? 24'($urandom_range(1))
                            : 24'($urandom()));
    write_reg(REG_SAMPLE_WINDOW, ($urandom_range(7) == 0) ? 24'($urandom())
                                 : 24'($urandom_range(2048, 1)));
    write_reg(REG_ANGLE_FLOOR, fl);
    write_reg(REG_ANGLE_CEILING, cl);
  endtask

  initial begin
    int unsigned n_phase;
    rst_n = 1'b0;
    cycles = 0;
    errors = 0;
    checked = 0;
    accepted = 0;
    volt_count = 0;
    corr_hits = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_if.valid = 1'b0;
    in_if.sum_squares = '0;
    in_if.zc_phase_a = 1'b0;
    in_if.zc_phase_b = 1'b0;
    in_if.zc_phase_c = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_POWER_REQUEST;
    cfg_if.data = '0;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults (setpoint zero, angle off), field extremes
    push_sample('0, 3'b111);
    push_sample('1, 3'b111);
    push_sample(40'd1024 * 100 * 100, 3'b000);
    push_sample(40'd1024 * 100 * 100, 3'b101);
    push_sample('1, 3'b010);
    push_sample(40'd1024 * 40 * 40, 3'b111);
    drain();

    // Directed: request in the correction band, then zero-cross gaps
    write_reg(REG_POWER_REQUEST, 24'd500);
    for (int i = 0; i < 8; i++)
      push_sample(40'd1024 * 60 * 60, (i < 4) ? 3'b111 : 3'(i));
    drain();

    // Directed: zero divisors, crossed limits, request above the max
    write_reg(REG_SAMPLE_WINDOW, 24'd0);
    write_reg(REG_LOOP_LAG, 24'd0);
    write_reg(REG_ANGLE_FLOOR, 24'd5000);
    write_reg(REG_ANGLE_CEILING, 24'd1000);
    write_reg(REG_POWER_REQUEST, 24'hFFFF);
    write_reg(REG_CURRENT_SCALE, 24'hFFFFFF);
    write_reg(REG_VOLTAGE_SCALE, 24'd0);
    for (int i = 0; i < 6; i++) push_sample((i % 2) ? 40'd90000 : '1, 3'b111);
    drain();
    write_reg(REG_POWER_MAX, 24'd0);
    write_reg(REG_VOLTAGE_SCALE, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) push_sample(40'd250000, 3'b111);
    drain();

    // Random phases: idle mix shifts from receiver-heavy to sender-heavy
    // to none, with a fresh register set each phase.
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 32;
        recv_idle_pct = 66;
      end else if (p < 8) begin
        send_idle_pct = 66;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      n_phase = $urandom_range(100, 80);
      for (int i = 0; i < n_phase; i++) push_sample(pick_sum(), pick_zc());
      drain();
    end

    $display("%0d measurements checked (%0d voltage, %0d correction-band angles)",
             checked, volt_count, corr_hits);
    $display("12 random register sets, directed extremes, zero divisors, crossed limits");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rpr_pkg.sv
rtl/rpr_if.sv
rtl/rpr_div.sv
rtl/rpr_isqrt.sv
rtl/rpr_mul.sv
rtl/three_phase_rms_power_regulator.sv
verif/tb_three_phase_rms_power_regulator.sv
